### design/fldsh_pkg.sv
// Package for the four-lane DJB string hash: lane count, seed, byte mask,
// derived widths and the per-word step result type.
// No dependencies.
`default_nettype none

package fldsh_pkg;

    // Number of interleaved hash lanes (valid range 1 to 8)
    localparam int LANES = 4;

    // Width of the word slot counter, at least one bit
    localparam int SLOT_W = (LANES > 1) ? $clog2(LANES) : 1;

    // Lane positions visible on the two wide result ports
    localparam int PORT_LANES = 4;

    // Size of the zero-padded lane view used to fill the result ports
    localparam int PAD_LANES = (LANES > PORT_LANES) ? LANES : PORT_LANES;

    localparam logic [31:0] HASH_SEED = 32'd5381;
    localparam logic [7:0]  BYTE_MASK = 8'hff;

    // Result of hashing one word into one lane
    typedef struct packed {
        logic [31:0] hash;
        logic        found;
    } fldsh_step_t;

endpackage : fldsh_pkg

`default_nettype wire

### design/fldsh_lane_step.sv
// One word of the DJB update: clip the bytes at and after the terminator,
// then fold the four bytes into a lane hash. Uses fldsh_pkg.
`default_nettype none

module fldsh_lane_step (
    input  wire logic [31:0]         lane_in,
    input  wire logic [31:0]         text_word,
    input  wire logic                terminator_seen,
    output fldsh_pkg::fldsh_step_t   step
);
    import fldsh_pkg::*;

    logic [3:0]  byte_zero;
    logic [3:0]  byte_keep;
    logic [31:0] clipped;
    logic [31:0] h;

    // Find zero bytes and keep only those below the first one
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            byte_zero[i] = (text_word[8*i +: 8] == 8'h00);
        end
        byte_keep[0] = !byte_zero[0];
        for (int i = 1; i < 4; i++)
        begin
            byte_keep[i] = byte_keep[i-1] && !byte_zero[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            clipped[8*i +: 8] = (byte_keep[i] && !terminator_seen)
                                ? (text_word[8*i +: 8] & BYTE_MASK) : 8'h00;
        end
    end

    // Apply h = h*33 + byte, highest byte first
    always_comb
    begin
        h = lane_in;
        for (int i = 3; i >= 0; i--)
        begin
            h = h + {h[26:0], 5'b00000} + {24'h000000, clipped[8*i +: 8]};
        end
        step.hash  = h;
        step.found = !terminator_seen && (byte_zero != 4'b0000);
    end

endmodule : fldsh_lane_step

`default_nettype wire

### design/four_lane_djb_string_hash.sv
// Top level of the four-lane interleaved DJB string hash.
// Depends on fldsh_pkg and fldsh_lane_step.
`default_nettype none

// Takes one 32-bit string word per cycle when not stalled; word k updates
// lane k mod LANES. An accepted word is held in the input register, and
// its lane is updated in the same cycle it leaves that register. After the
// last word of the block that holds the terminator, the lanes and their XOR
// fold appear in the output register the next cycle and the lanes restart
// at 5381. The input side stalls only while a result-producing word waits
// on a full output register that is itself stalled.
module four_lane_djb_string_hash (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] text_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      lanes_low,
    output logic [63:0]      lanes_high,
    output logic [31:0]      folded_hash
);
    import fldsh_pkg::*;

    // Input register
    logic              in_valid_reg;
    logic [31:0]       word_reg;

    // Hash state
    logic [31:0]       lane_reg [LANES];
    logic [31:0]       lane_next [LANES];
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic              term_reg;
    logic              term_next;

    // Output register
    logic              out_valid_reg;
    logic [63:0]       low_reg;
    logic [63:0]       high_reg;
    logic [31:0]       fold_reg;
    logic [63:0]       low_next;
    logic [63:0]       high_next;
    logic [31:0]       fold_next;

    fldsh_step_t       step;
    logic              last_slot;
    logic              emit;
    logic              out_free;
    logic              fire;
    logic [31:0]       pad [PAD_LANES];

    fldsh_lane_step u_step (
        .lane_in         (lane_reg[slot_reg]),
        .text_word       (word_reg),
        .terminator_seen (term_reg),
        .step            (step)
    );

    // Decide whether the held item can advance this cycle
    always_comb
    begin
        last_slot = (slot_reg == SLOT_W'(LANES - 1));
        emit      = last_slot && (term_reg || step.found);
        out_free  = !out_valid_reg || !out_stall;
        fire      = in_valid_reg && (!emit || out_free);
        in_stall  = in_valid_reg && !fire;
    end

    // Next lane state, slot and terminator flag
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            lane_next[i] = lane_reg[i];
        end
        lane_next[slot_reg] = step.hash;
        slot_next = last_slot ? '0 : slot_reg + SLOT_W'(1);
        term_next = term_reg || step.found;
    end

    // Build the result from the updated lanes
    always_comb
    begin
        for (int i = 0; i < PAD_LANES; i++)
        begin
            pad[i] = 32'h0;
        end
        fold_next = 32'h0;
        for (int i = 0; i < LANES; i++)
        begin
            pad[i]    = lane_next[i];
            fold_next = fold_next ^ lane_next[i];
        end
        low_next  = {pad[1], pad[0]};
        high_next = {pad[3], pad[2]};
    end

    // Load the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            word_reg <= text_word;
        end
    end

    // Advance the hash state; restart it after a result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                lane_reg[i] <= HASH_SEED;
            end
            slot_reg <= '0;
            term_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (emit)
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    lane_reg[i] <= HASH_SEED;
                end
                slot_reg <= '0;
                term_reg <= 1'b0;
            end
            else
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    lane_reg[i] <= lane_next[i];
                end
                slot_reg <= slot_next;
                term_reg <= last_slot ? term_reg : term_next;
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            low_reg  <= low_next;
            high_reg <= high_next;
            fold_reg <= fold_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign lanes_low   = low_reg;
    assign lanes_high  = high_reg;
    assign folded_hash = fold_reg;

endmodule : four_lane_djb_string_hash

`default_nettype wire

### dv/four_lane_djb_string_hash_tb.sv
// Testbench for four_lane_djb_string_hash: drives zero-terminated strings as words
// with random pacing; checks every digest against a lane-hash predictor or a constant.
// Depends on fldsh_pkg and the four_lane_djb_string_hash RTL.
`default_nettype none

module four_lane_djb_string_hash_tb;

    import fldsh_pkg::*;

    localparam int RANDOM_WORDS = 1730;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AT      = 800;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic [31:0] fold;
    } digest_t;

    typedef struct packed {
        logic [31:0] word;
        logic        typed;
        digest_t     want;
    } stim_row_t;

    // Four zero words after reset: every lane is 5381 * 33^4, so the fold is zero
    localparam digest_t ZERO_BLOCK =
        {64'h7C5D0F85_7C5D0F85, 64'h7C5D0F85_7C5D0F85, 32'h0000_0000};
    localparam digest_t NO_DIGEST = '0;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] text_word;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] lanes_low;
    logic [63:0] lanes_high;
    logic [31:0] folded_hash;

    // Predictor state
    logic [31:0] lane_acc [LANES];
    int unsigned next_lane;
    bit          term_seen;

    digest_t     pending_digests [$];
    stim_row_t   dir_table [20];

    int          err_count;
    int          words_taken;
    int          digests_seen;
    int          cycle_count;
    int          rx_wait;
    bit          rx_idle;
    bit          tx_idle;
    bit          long_hold;
    digest_t     got_digest;
    digest_t     want_digest;

    four_lane_djb_string_hash DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .text_word   (text_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .lanes_low   (lanes_low),
        .lanes_high  (lanes_high),
        .folded_hash (folded_hash)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // One DJB step: h * 33 + byte, wrapping at 32 bits
    function automatic logic [31:0] djb_mix(input logic [31:0] h, input logic [7:0] b);
        return (h << 5) + h + {24'h0, b};
    endfunction

    // Restart all lanes at the seed
    task automatic clear_lanes();
        int i;
        for (i = 0; i < LANES; i++)
            lane_acc[i] = HASH_SEED;
        next_lane = 0;
        term_seen = 1'b0;
    endtask

    // Fold one accepted word into its lane; report a digest when a terminated block ends
    task automatic absorb_word(input logic [31:0] w, output bit done, output digest_t d);
        int          i;
        bit          hit;
        logic [31:0] h;
        logic [31:0] view [4];
        logic [31:0] fold;
        // zero the terminator and everything after it
        hit = term_seen;
        for (i = 0; i < 4; i++)
        begin
            if (w[8*i +: 8] == 8'h00)
                hit = 1'b1;
            if (hit)
                w[8*i +: 8] = 8'h00;
        end
        term_seen = hit;
        // bytes enter from bits 31:24 down to 7:0
        h = lane_acc[next_lane];
        for (i = 3; i >= 0; i--)
            h = djb_mix(h, w[8*i +: 8]);
        lane_acc[next_lane] = h;
        done = 1'b0;
        d = NO_DIGEST;
        if (next_lane + 1 < LANES)
        begin
            next_lane++;
        end
        else
        begin
            next_lane = 0;
            if (term_seen)
            begin
                fold = '0;
                for (i = 0; i < LANES; i++)
                    fold ^= lane_acc[i];
                for (i = 0; i < 4; i++)
                    view[i] = (i < LANES) ? lane_acc[i] : 32'h0;
                d = {view[1], view[0], view[3], view[2], fold};
                done = 1'b1;
                clear_lanes();
            end
        end
    endtask

    // Offer one item after a random gap, hold it until taken, then predict
    task automatic push_word(input logic [31:0] w, input bit typed, input digest_t typed_want);
        int      gap;
        bit      done;
        digest_t d;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        text_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_taken++;
        if (words_taken % 150 == 0)
            tx_idle = ($urandom_range(0, 3) != 0);
        absorb_word(w, done, d);
        if (done)
            pending_digests.push_back(typed ? typed_want : d);
        @(negedge clk);
    endtask

    // Send a string of len nonzero bytes, its terminator, and garbage up to block end
    task automatic send_string(input int len);
        int          nwords;
        int          nblk;
        int          k;
        int          b;
        int          idx;
        logic [31:0] w;
        nwords = len / 4 + 1;
        nblk = ((nwords + LANES - 1) / LANES) * LANES;
        for (k = 0; k < nblk; k++)
        begin
            for (b = 0; b < 4; b++)
            begin
                idx = 4 * k + b;
                if (idx < len)
                    w[8*b +: 8] = 8'($urandom_range(1, 255));
                else if (idx == len)
                    w[8*b +: 8] = 8'h00;
                else
                    w[8*b +: 8] = 8'($urandom_range(0, 255));
            end
            push_word(w, 1'b0, NO_DIGEST);
        end
    endtask

    task automatic note_error(input string what, input digest_t want, input digest_t got);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s: expected lo=%h hi=%h fold=%h, got lo=%h hi=%h fold=%h",
                     $time, what, want.lo, want.hi, want.fold, got.lo, got.hi, got.fold);
    endtask

    // Check each taken digest against the oldest prediction, then draw the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_digest = {lanes_low, lanes_high, folded_hash};
            if (pending_digests.size() == 0)
            begin
                note_error("unexpected digest", NO_DIGEST, got_digest);
            end
            else
            begin
                want_digest = pending_digests.pop_front();
                if (got_digest.lo !== want_digest.lo || got_digest.hi !== want_digest.hi
                    || got_digest.fold !== want_digest.fold)
                    note_error("digest mismatch", want_digest, got_digest);
            end
            digests_seen++;
            if (digests_seen % 32 == 0)
                rx_idle = ($urandom_range(0, 2) != 0);
            rx_wait = rx_idle ? $urandom_range(0, 5) : 0;
        end
    end

    // Drive the output stall from the drawn wait and the long hold
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= long_hold || (rx_wait > 0);
            if (rx_wait > 0)
                rx_wait--;
        end
    end

    // Hold the output for a long stretch once traffic is flowing
    initial
    begin
        long_hold = 1'b0;
        wait (words_taken >= HOLD_AT);
        @(posedge clk);
        long_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int sel;
        int n;
        int r;
        in_valid     = 1'b0;
        text_word    = 32'h0;
        out_stall    = 1'b0;
        rst_n        = 1'b0;
        err_count    = 0;
        words_taken  = 0;
        digests_seen = 0;
        cycle_count  = 0;
        rx_wait      = 0;
        rx_idle      = 1'b1;
        tx_idle      = 1'b1;
        clear_lanes();

        // all-zero block straight after reset
        dir_table[0]  = {32'h0000_0000, 1'b0, NO_DIGEST};
        dir_table[1]  = {32'h0000_0000, 1'b0, NO_DIGEST};
        dir_table[2]  = {32'h0000_0000, 1'b0, NO_DIGEST};
        dir_table[3]  = {32'h0000_0000, 1'b1, ZERO_BLOCK};
        // terminator in the first byte hides everything after it
        dir_table[4]  = {32'hFFFF_FF00, 1'b0, NO_DIGEST};
        dir_table[5]  = {32'hFFFF_FFFF, 1'b0, NO_DIGEST};
        dir_table[6]  = {32'hFFFF_FFFF, 1'b0, NO_DIGEST};
        dir_table[7]  = {32'hFFFF_FFFF, 1'b1, ZERO_BLOCK};
        // a block with no terminator keeps accumulating
        dir_table[8]  = {32'hFFFF_FFFF, 1'b0, NO_DIGEST};
        dir_table[9]  = {32'hFFFF_FFFF, 1'b0, NO_DIGEST};
        dir_table[10] = {32'h8080_8080, 1'b0, NO_DIGEST};
        dir_table[11] = {32'h7F7F_7F7F, 1'b0, NO_DIGEST};
        // terminator in the top byte, then garbage words in the same block
        dir_table[12] = {32'h0101_0101, 1'b0, NO_DIGEST};
        dir_table[13] = {32'h00FF_FFFF, 1'b0, NO_DIGEST};
        dir_table[14] = {32'h1234_5678, 1'b0, NO_DIGEST};
        dir_table[15] = {32'hFFFF_FFFF, 1'b0, NO_DIGEST};
        // terminator in byte 2 (bits 23:16) of the last word of a block
        dir_table[16] = {32'h1111_1111, 1'b0, NO_DIGEST};
        dir_table[17] = {32'h2222_2222, 1'b0, NO_DIGEST};
        dir_table[18] = {32'h3333_3333, 1'b0, NO_DIGEST};
        dir_table[19] = {32'hAB00_CDEF, 1'b0, NO_DIGEST};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part
        for (n = 0; n < 20; n++)
            push_word(dir_table[n].word, dir_table[n].typed, dir_table[n].want);

        // random part: mostly whole strings, some loose words that shift alignment
        while (words_taken < 20 + RANDOM_WORDS)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
            begin
                r = $urandom_range(1, 3);
                for (n = 0; n < r; n++)
                    push_word($urandom(), 1'b0, NO_DIGEST);
            end
            else
            begin
                r = $urandom_range(0, 7);
                if (r == 0)
                    send_string($urandom_range(0, 3));
                else if (r < 6)
                    send_string($urandom_range(0, 40));
                else
                    send_string($urandom_range(41, 120));
            end
        end
        in_valid <= 1'b0;

        // drain outstanding digests, then let the pipeline settle
        while (pending_digests.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (pending_digests.size() != 0)
            err_count++;
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule : four_lane_djb_string_hash_tb

`default_nettype wire

### files.f
design/fldsh_pkg.sv
design/fldsh_lane_step.sv
design/four_lane_djb_string_hash.sv
dv/four_lane_djb_string_hash_tb.sv
